// ===== design/weight_stats_colormap_defines.svh =====
// Assertion macros for the node statistics colormap block.
// Taken in by the top level; depends on nothing else.
`ifndef WEIGHT_STATS_COLORMAP_DEFINES_SVH
`define WEIGHT_STATS_COLORMAP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define WSC_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define WSC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/wsc_pkg.sv =====
// Shared constants and types of the node statistics colormap block.
// No dependencies; used by every module of the block.
package wsc_pkg;

    localparam int unsigned STAT_W  = 23;
    localparam int unsigned MEAN_W  = 24;
    localparam int unsigned RATIO_W = 17;
    localparam int unsigned BASE_W  = 24;

    localparam logic [RATIO_W-1:0] ONE_Q16 = 17'd65536;
    localparam logic [RATIO_W-1:0] K018    = 17'd11796;
    localparam logic [RATIO_W-1:0] K082    = 17'd53740;
    localparam logic [RATIO_W-1:0] K034    = 17'd22282;

    // Palette entries, red / green / blue.
    localparam logic [7:0] BG_COL    [3] = '{8'd14,  8'd16,  8'd20};
    localparam logic [7:0] WARM_COL  [3] = '{8'd246, 8'd127, 8'd33};
    localparam logic [7:0] COOL_COL  [3] = '{8'd44,  8'd140, 8'd255};
    localparam logic [7:0] NEUT_COL  [3] = '{8'd120, 8'd196, 8'd130};
    localparam logic [7:0] DRIFT_COL [3] = '{8'd255, 8'd52,  8'd52};

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_SIGNED_SCALE = 2'd0,
        CFG_ENERGY_SCALE = 2'd1,
        CFG_DRIFT_SCALE  = 2'd2
    } t_cfg_idx;

endpackage

// ===== design/weight_stats_colormap.sv =====
// Throughput: one item per cycle unless the output stalls; the 16-bit quotient
// of each ratio is resolved four bits per stage over four divider stages, then
// three mix stages.
// Stages that hold no item fill while the output is stalled.
// Reset (synchronous, active low) empties the pipeline and sets all scales to 1.0.
module weight_stats_colormap (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic signed [wsc_pkg::MEAN_W-1:0] i_mean_value,
    input  logic [wsc_pkg::STAT_W-1:0]   i_mean_magnitude,
    input  logic [wsc_pkg::STAT_W-1:0]   i_drift_magnitude,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [7:0]                   o_red,
    output logic [7:0]                   o_green,
    output logic [7:0]                   o_blue,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [1:0]                   i_cfg_index,
    input  logic [wsc_pkg::STAT_W-1:0]   i_cfg_data
);
    import wsc_pkg::*;
    `include "weight_stats_colormap_defines.svh"

    logic [STAT_W-1:0]  r_signed_scale;
    logic [STAT_W-1:0]  r_energy_scale;
    logic [STAT_W-1:0]  r_drift_scale;
    logic [7:0]         r_vld;
    logic [7:0]         w_en;
    logic [MEAN_W-1:0]  w_mmag;
    logic               r_neg [0:4];
    logic               r_dnz [0:4];
    logic [RATIO_W-1:0] w_sv;
    logic [RATIO_W-1:0] w_energy;
    logic [RATIO_W-1:0] w_drift;

    // Configuration writes; an index past the list is ignored.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_signed_scale <= STAT_W'(65536);
            r_energy_scale <= STAT_W'(65536);
            r_drift_scale  <= STAT_W'(65536);
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_SIGNED_SCALE: r_signed_scale <= i_cfg_data;
                CFG_ENERGY_SCALE: r_energy_scale <= i_cfg_data;
                CFG_DRIFT_SCALE:  r_drift_scale  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // A stage advances when it is empty or the stage after it advances.
    always_comb begin
        w_en[7] = !r_vld[7] || i_out_ready;
        for (int k = 6; k >= 0; k--) begin
            w_en[k] = !r_vld[k] || w_en[k+1];
        end
    end

    assign o_in_ready  = w_en[0];
    assign o_out_valid = r_vld[7];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[0]) begin
                r_vld[0] <= i_in_valid;
            end
            for (int k = 1; k < 8; k++) begin
                if (w_en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // Magnitude of the signed mean; the most negative code maps to 2^23.
    assign w_mmag = i_mean_value[MEAN_W-1] ? (MEAN_W'(0) - MEAN_W'(i_mean_value))
                                           : MEAN_W'(i_mean_value);

    // Sign and drift-present flags ride along with the divider stages.
    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_neg[0] <= i_mean_value[MEAN_W-1];
            r_dnz[0] <= (i_drift_magnitude != '0);
        end
        for (int k = 1; k < 5; k++) begin
            if (w_en[k]) begin
                r_neg[k] <= r_neg[k-1];
                r_dnz[k] <= r_dnz[k-1];
            end
        end
    end

    wsc_div u_div_signed (
        .i_clk   (i_clk),
        .i_en    (w_en[4:0]),
        .i_mag   (w_mmag),
        .i_scale (r_signed_scale),
        .o_ratio (w_sv)
    );

    wsc_div u_div_energy (
        .i_clk   (i_clk),
        .i_en    (w_en[4:0]),
        .i_mag   ({1'b0, i_mean_magnitude}),
        .i_scale (r_energy_scale),
        .o_ratio (w_energy)
    );

    wsc_div u_div_drift (
        .i_clk   (i_clk),
        .i_en    (w_en[4:0]),
        .i_mag   ({1'b0, i_drift_magnitude}),
        .i_scale (r_drift_scale),
        .o_ratio (w_drift)
    );

    wsc_mix u_mix (
        .i_clk    (i_clk),
        .i_en     (w_en[7:5]),
        .i_sv     (w_sv),
        .i_energy (w_energy),
        .i_drift  (w_drift),
        .i_neg    (r_neg[4]),
        .i_dnz    (r_dnz[4]),
        .o_red    (o_red),
        .o_green  (o_green),
        .o_blue   (o_blue)
    );

    // An empty entry stage always takes a transfer.
    `WSC_ASSERT_NOW(a_entry_free, i_clk, i_rst_n, !r_vld[0], o_in_ready, "entry stage empty but not ready")
    // A held result stays in the output stage.
    `WSC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, r_vld[7] && !i_out_ready, r_vld[7], "stalled result dropped")
    // Ratios leaving the dividers never exceed 1.0.
    `WSC_ASSERT_NOW(a_ratio_clamp, i_clk, i_rst_n, r_vld[4], (w_sv <= ONE_Q16) && (w_energy <= ONE_Q16) && (w_drift <= ONE_Q16), "ratio above one")

endmodule

// ===== design/wsc_div.sv =====
// Pipelined ratio unit: (mag << 16) / scale, clamped to 1.0 in Q1.16.
// Depends on wsc_pkg. Five register stages, four quotient bits per stage after the entry stage.
module wsc_div (
    input  logic                         i_clk,
    input  logic [4:0]                   i_en,
    input  logic [wsc_pkg::MEAN_W-1:0]   i_mag,
    input  logic [wsc_pkg::STAT_W-1:0]   i_scale,
    output logic [wsc_pkg::RATIO_W-1:0]  o_ratio
);
    import wsc_pkg::*;

    logic [STAT_W-1:0] w_scale;
    logic [STAT_W-1:0] r_rem [0:4];
    logic [15:0]       r_q   [0:4];
    logic              r_sat [0:4];

    // A zero scale acts as one LSB.
    assign w_scale = (i_scale == '0) ? STAT_W'(1) : i_scale;

    // Entry stage: a magnitude at or above the scale saturates to 1.0,
    // otherwise the quotient fits in 16 bits and the remainder in 23.
    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_sat[0] <= (i_mag >= {1'b0, w_scale});
            r_rem[0] <= i_mag[STAT_W-1:0];
            r_q[0]   <= '0;
        end
    end

    // Restoring division, four quotient bits in each stage.
    for (genvar s = 1; s <= 4; s++) begin : g_stage
        logic [STAT_W-1:0] n_rem;
        logic [15:0]       n_q;

        always_comb begin
            logic [STAT_W:0] sh;
            n_rem = r_rem[s-1];
            n_q   = r_q[s-1];
            for (int b = 0; b < 4; b++) begin
                sh = {n_rem, 1'b0};
                if (sh >= {1'b0, w_scale}) begin
                    sh  = sh - {1'b0, w_scale};
                    n_q = {n_q[14:0], 1'b1};
                end else begin
                    n_q = {n_q[14:0], 1'b0};
                end
                n_rem = sh[STAT_W-1:0];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en[s]) begin
                r_rem[s] <= n_rem;
                r_q[s]   <= n_q;
                r_sat[s] <= r_sat[s-1];
            end
        end
    end

    assign o_ratio = r_sat[4] ? ONE_Q16 : {1'b0, r_q[4]};

endmodule

// ===== design/wsc_mix.sv =====
// Palette mixing, intensity blend and drift blend, three register stages.
// Depends on wsc_pkg.
module wsc_mix (
    input  logic                         i_clk,
    input  logic [2:0]                   i_en,
    input  logic [wsc_pkg::RATIO_W-1:0]  i_sv,
    input  logic [wsc_pkg::RATIO_W-1:0]  i_energy,
    input  logic [wsc_pkg::RATIO_W-1:0]  i_drift,
    input  logic                         i_neg,
    input  logic                         i_dnz,
    output logic [7:0]                   o_red,
    output logic [7:0]                   o_green,
    output logic [7:0]                   o_blue
);
    import wsc_pkg::*;

    logic [BASE_W-1:0]  r_base  [3];
    logic [BASE_W-1:0]  n_base  [3];
    logic [RATIO_W-1:0] r_inten;
    logic [RATIO_W-1:0] n_inten;
    logic [RATIO_W-1:0] r_blend5;
    logic [RATIO_W-1:0] n_blend;
    logic               r_dnz5;

    logic [BASE_W-1:0]  r_col   [3];
    logic [BASE_W-1:0]  n_col   [3];
    logic [RATIO_W-1:0] r_blend6;
    logic               r_dnz6;

    logic [7:0]         r_px    [3];
    logic [7:0]         n_px    [3];

    // Palette weights, base colors and the two blend weights.
    always_comb begin
        logic [RATIO_W-1:0] warm;
        logic [RATIO_W-1:0] cool;
        logic [RATIO_W-1:0] neutral;
        logic [33:0]        pe;
        logic [33:0]        pd;
        warm    = i_neg ? '0 : i_sv;
        cool    = i_neg ? i_sv : '0;
        neutral = ONE_Q16 - i_sv;
        for (int ch = 0; ch < 3; ch++) begin
            n_base[ch] = BASE_W'(26'(warm) * 26'(WARM_COL[ch])
                               + 26'(cool) * 26'(COOL_COL[ch])
                               + 26'(neutral) * 26'(NEUT_COL[ch]));
        end
        pe      = 34'(K082) * 34'(i_energy);
        pd      = 34'(K034) * 34'(i_drift);
        n_inten = K018 + pe[32:16];
        n_blend = K018 + pd[32:16];
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_base   <= n_base;
            r_inten  <= n_inten;
            r_blend5 <= n_blend;
            r_dnz5   <= i_dnz;
        end
    end

    // Blend from the background by intensity.
    always_comb begin
        logic [RATIO_W-1:0] inv;
        logic [40:0]        pm;
        inv = ONE_Q16 - r_inten;
        for (int ch = 0; ch < 3; ch++) begin
            pm         = 41'(r_base[ch]) * 41'(r_inten);
            n_col[ch]  = BASE_W'(26'(BG_COL[ch]) * 26'(inv) + 26'(pm[40:16]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_col    <= n_col;
            r_blend6 <= r_blend5;
            r_dnz6   <= r_dnz5;
        end
    end

    // Drift blend toward red, then integer part with saturation.
    always_comb begin
        logic [RATIO_W-1:0] inv;
        logic [40:0]        pm;
        logic [25:0]        c2;
        inv = ONE_Q16 - r_blend6;
        for (int ch = 0; ch < 3; ch++) begin
            pm = 41'(r_col[ch]) * 41'(inv);
            if (r_dnz6) begin
                c2 = 26'(pm[40:16]) + 26'(DRIFT_COL[ch]) * 26'(r_blend6);
            end else begin
                c2 = 26'(r_col[ch]);
            end
            n_px[ch] = (c2[25:16] > 10'd255) ? 8'd255 : c2[23:16];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            r_px <= n_px;
        end
    end

    assign o_red   = r_px[0];
    assign o_green = r_px[1];
    assign o_blue  = r_px[2];

endmodule
